// ----- sv/rotation_error_angle_macros.svh -----
// assertion helpers for the rotation error angle block
`ifndef ROTATION_ERROR_ANGLE_MACROS_SVH
`define ROTATION_ERROR_ANGLE_MACROS_SVH

// concurrent check on the rising clock edge, off while reset is low
`define REA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication checked only when the output channel holds a beat
`define REA_ASSERT_OUT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    out_valid_o |-> (prop)) else $error(msg);

`endif

// ----- sv/rea_pkg.sv -----
`timescale 1ns / 1ps

package rea_pkg;

  // fixed field and datapath widths
  localparam int unsigned ENTRY_W    = 16;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned ACC_W      = 36;
  localparam int unsigned UNIT_W     = 31;  // unsigned Q30, holds 1.0
  localparam int unsigned SQ_W       = 62;
  localparam int unsigned XY_W       = 34;
  localparam int unsigned Z_W        = 33;
  localparam int unsigned ATAN_W     = 30;
  localparam int unsigned STEP_CNT_W = 6;   // covers up to 64 rotation steps
  localparam int unsigned ROOT_K_W   = 5;

  localparam logic [Z_W-1:0]     DEG90     = Z_W'(64'd90 << 24);
  localparam logic [Z_W-1:0]     DEG180    = Z_W'(64'd180 << 24);
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(46080);

  typedef struct packed {
    logic signed [ENTRY_W-1:0] est_entry;
    logic signed [ENTRY_W-1:0] ref_entry;
    logic                      last_pair;
  } in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_deg;
    logic               cos_clamped;
  } out_t;

  typedef struct packed {
    logic beat;     // input beat accepted, multiply it
    logic capture;  // take the finished trace and clear it
  } trace_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_PREP,
    ST_LAUNCH,
    ST_ROOT,
    ST_ROTATE,
    ST_EMIT
  } state_e;

  // atan(2^-i) in units of 2^-24 degree
  function automatic logic [ATAN_W-1:0] atan_deg(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = ATAN_W'(754974720);
      5'd1:    v = ATAN_W'(445687602);
      5'd2:    v = ATAN_W'(235489088);
      5'd3:    v = ATAN_W'(119537938);
      5'd4:    v = ATAN_W'(60000934);
      5'd5:    v = ATAN_W'(30029717);
      5'd6:    v = ATAN_W'(15018523);
      5'd7:    v = ATAN_W'(7509720);
      5'd8:    v = ATAN_W'(3754917);
      5'd9:    v = ATAN_W'(1877466);
      5'd10:   v = ATAN_W'(938734);
      5'd11:   v = ATAN_W'(469367);
      5'd12:   v = ATAN_W'(234684);
      5'd13:   v = ATAN_W'(117342);
      5'd14:   v = ATAN_W'(58671);
      5'd15:   v = ATAN_W'(29335);
      5'd16:   v = ATAN_W'(14668);
      5'd17:   v = ATAN_W'(7334);
      5'd18:   v = ATAN_W'(3667);
      5'd19:   v = ATAN_W'(1833);
      5'd20:   v = ATAN_W'(917);
      5'd21:   v = ATAN_W'(458);
      5'd22:   v = ATAN_W'(229);
      5'd23:   v = ATAN_W'(115);
      5'd24:   v = ATAN_W'(57);
      5'd25:   v = ATAN_W'(29);
      5'd26:   v = ATAN_W'(14);
      5'd27:   v = ATAN_W'(7);
      5'd28:   v = ATAN_W'(4);
      5'd29:   v = ATAN_W'(2);
      5'd30:   v = ATAN_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/rotation_error_angle.sv -----
`timescale 1ns / 1ps

// channel | dir | handshake            | payload
// in      | in  | in_valid_i/in_stall_o | est_entry, ref_entry, last_pair
// out     | out | out_valid_o/out_stall_i | angle_deg, cos_clamped
//
// a beat without last_pair is taken every cycle while the block is idle and costs one multiply-add
// a beat with last_pair holds the input while the matrix is worked out: trace
// finish, 62-bit square, bit-pair square root, then one CORDIC step per cycle
// in the vectoring unit
// the result sits in an output register; a stalled result only delays the next
// matrix once its own angle is done
// reset clears the trace accumulator and all control state

module rotation_error_angle #(
  parameter int unsigned FRAC_BITS    = 14,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rea_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rea_pkg::out_t out_data_o
);
  import rea_pkg::*;

  state_e              state_q, state_d;
  trace_ctl_t          trace_ctl;
  logic                in_beat, out_free, sqrt_start, sqrt_done, rot_done;
  logic [UNIT_W-1:0]   cos_mag, sin_mag;
  logic                cos_neg, cos_clamped;
  logic [ANGLE_W-1:0]  angle;
  logic                out_valid_q;
  out_t                out_q;

  assign in_beat  = in_valid_i & ~in_stall_o;
  assign out_free = ~out_valid_q | ~out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_beat && in_data_i.last_pair) begin
        state_d = ST_ACCUM;
      end
      ST_ACCUM:  state_d = ST_PREP;
      ST_PREP:   state_d = ST_LAUNCH;
      ST_LAUNCH: state_d = ST_ROOT;
      ST_ROOT:   if (sqrt_done) begin
        state_d = ST_ROTATE;
      end
      ST_ROTATE: if (rot_done) begin
        state_d = ST_EMIT;
      end
      ST_EMIT:   if (out_free) begin
        state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o        = 1'b1;
    trace_ctl.capture = 1'b0;
    sqrt_start        = 1'b0;
    case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_PREP:   trace_ctl.capture = 1'b1;
      ST_LAUNCH: sqrt_start = 1'b1;
      default:   ;
    endcase
    trace_ctl.beat = in_beat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  rea_trace #(
    .FRAC_BITS (FRAC_BITS)
  ) u_trace (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (trace_ctl),
    .beat_i    (in_data_i),
    .mag_o     (cos_mag),
    .neg_o     (cos_neg),
    .clamped_o (cos_clamped)
  );

  rea_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .cos_i   (cos_mag),
    .done_o  (sqrt_done),
    .sin_o   (sin_mag)
  );

  rea_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_done),
    .x_i     (cos_mag),
    .y_i     (sin_mag),
    .neg_i   (cos_neg),
    .done_o  (rot_done),
    .angle_o (angle)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && out_free) begin
      out_q.angle_deg   <= angle;
      out_q.cos_clamped <= cos_clamped;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/rea_trace.sv -----
`timescale 1ns / 1ps

module rea_trace #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rea_pkg::trace_ctl_t      ctl_i,
  input  rea_pkg::in_t             beat_i,
  output logic [rea_pkg::UNIT_W-1:0] mag_o,
  output logic                     neg_o,
  output logic                     clamped_o
);
  import rea_pkg::*;

  // width that holds trace - 1 and its saturation bound for any fraction count
  localparam int unsigned DW  = ((2 * FRAC_BITS + 3) > (ACC_W + 2)) ?
                                (2 * FRAC_BITS + 3) : (ACC_W + 2);
  localparam int unsigned SHL = (2 * FRAC_BITS + 1 <= 30) ? (29 - 2 * FRAC_BITS) : 0;
  localparam int unsigned SHR = (2 * FRAC_BITS + 1 <= 30) ? 0 : (2 * FRAC_BITS - 29);
  localparam logic [DW-1:0] ONE2 = DW'(1) << (2 * FRAC_BITS);
  localparam logic [DW-1:0] LIM  = DW'(1) << (2 * FRAC_BITS + 1);
  localparam logic [DW-1:0] UNIT = DW'(1) << 30;

  logic signed [2*ENTRY_W-1:0] prod_q;
  logic                        prod_vld_q;
  logic signed [ACC_W-1:0]     acc_q, acc_d;
  logic signed [DW-1:0]        acc_x, diff, diff_c;
  logic [DW-1:0]               mag, mag_s;
  logic                        over_hi, over_lo;
  logic [UNIT_W-1:0]           mag_q;
  logic                        neg_q, clamped_q;

  // product stage, one multiply per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctl_i.beat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.beat) begin
      prod_q <= beat_i.est_entry * beat_i.ref_entry;
    end
  end

  // trace accumulator, wraps modulo 2^36
  always_comb begin
    acc_d = acc_q;
    if (ctl_i.capture) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // cosine with one extra fraction bit, saturated, then magnitude in Q30
  always_comb begin
    acc_x   = DW'(acc_q);
    diff    = acc_x - $signed(ONE2);
    over_hi = diff > $signed(LIM);
    over_lo = diff < -$signed(LIM);
    diff_c  = diff;
    if (over_hi) begin
      diff_c = $signed(LIM);
    end else if (over_lo) begin
      diff_c = -$signed(LIM);
    end
    mag   = diff_c[DW-1] ? DW'(-diff_c) : DW'(diff_c);
    mag_s = (mag << SHL) >> SHR;
    if (mag_s > UNIT) begin
      mag_s = UNIT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      mag_q     <= mag_s[UNIT_W-1:0];
      neg_q     <= diff_c[DW-1];
      clamped_q <= over_hi | over_lo;
    end
  end

  assign mag_o     = mag_q;
  assign neg_o     = neg_q;
  assign clamped_o = clamped_q;

endmodule

// ----- sv/rea_sqrt.sv -----
`timescale 1ns / 1ps

module rea_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rea_pkg::UNIT_W-1:0] cos_i,
  output logic                       done_o,
  output logic [rea_pkg::UNIT_W-1:0] sin_o
);
  import rea_pkg::*;

  localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << 60;

  logic [SQ_W-1:0]     sq_q;
  logic                load_q, run_q, done_q;
  logic [ROOT_K_W-1:0] k_q;
  logic [SQ_W-1:0]     rem_q, rem_d, root_q, root_d;
  logic [SQ_W-1:0]     bitv, cand;

  // one radicand bit pair a cycle, restoring square root
  always_comb begin
    bitv   = SQ_W'(1) << {k_q, 1'b0};
    cand   = root_q + bitv;
    rem_d  = rem_q;
    root_d = root_q >> 1;
    if (rem_q >= cand) begin
      rem_d  = rem_q - cand;
      root_d = (root_q >> 1) + bitv;
    end
  end

  // sequencing: square, load 1 - c^2, then 31 root steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= 1'b0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      load_q <= start_i;
      done_q <= 1'b0;
      if (load_q) begin
        run_q <= 1'b1;
        k_q   <= ROOT_K_W'(30);
      end else if (run_q) begin
        k_q <= k_q - 1'b1;
        if (k_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sq_q <= SQ_W'(cos_i) * SQ_W'(cos_i);
    end
    if (load_q) begin
      rem_q  <= ONE_SQ - sq_q;
      root_q <= '0;
    end else if (run_q) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign sin_o  = root_q[UNIT_W-1:0];

endmodule

// ----- sv/rea_cordic.sv -----
`timescale 1ns / 1ps

module rea_cordic #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rea_pkg::UNIT_W-1:0]  x_i,
  input  logic [rea_pkg::UNIT_W-1:0]  y_i,
  input  logic                        neg_i,
  output logic                        done_o,
  output logic [rea_pkg::ANGLE_W-1:0] angle_o
);
  import rea_pkg::*;

  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(CORDIC_STEPS - 1);

  logic signed [XY_W-1:0]  x_q, y_q, xs, ys;
  logic signed [Z_W-1:0]   z_q, atan_s;
  logic [STEP_CNT_W-1:0]   cnt_q;
  logic                    run_q, done_q;
  logic [Z_W-1:0]          z_c;
  logic [Z_W-1:0]          ang;
  logic [Z_W-1:0]          rnd;
  logic [Z_W-17:0]         ang_r;

  assign xs     = x_q >>> cnt_q[4:0];
  assign ys     = y_q >>> cnt_q[4:0];
  assign atan_s = $signed(Z_W'(atan_deg(cnt_q[4:0])));

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // vectoring rotation, drives y toward zero
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= XY_W'(x_i);
      y_q <= XY_W'(y_i);
      z_q <= '0;
    end else if (run_q) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_s;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_s;
      end
    end
  end

  // clamp to a quarter turn, mirror for negative cosine, round to Q8.8
  always_comb begin
    if (z_q[Z_W-1]) begin
      z_c = '0;
    end else if (z_q > $signed(DEG90)) begin
      z_c = DEG90;
    end else begin
      z_c = z_q;
    end
    ang   = neg_i ? (DEG180 - z_c) : z_c;
    rnd   = ang + Z_W'(1 << 15);
    ang_r = rnd[Z_W-1:16];
    if (ang_r > (Z_W-16)'(ANGLE_MAX)) begin
      angle_o = ANGLE_MAX;
    end else begin
      angle_o = ang_r[ANGLE_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

// ----- sv/rea_checker.sv -----
`timescale 1ns / 1ps
`include "rotation_error_angle_macros.svh"

module rea_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input rea_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input rea_pkg::out_t out_data_o
);
  import rea_pkg::*;

  // a stalled result beat stays up
  `REA_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result beat dropped")

  // a stalled result beat keeps its payload
  `REA_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(out_data_o), "result changed")

  // angle never passes 180 degrees
  `REA_ASSERT_OUT(a_angle_range, out_data_o.angle_deg <= ANGLE_MAX, "angle above 180 degrees")

  // the closing pair of a matrix blocks the input while the angle is worked out
  `REA_ASSERT(a_last_stalls, in_valid_i && !in_stall_o && in_data_i.last_pair |=> in_stall_o, "input open after last pair")

endmodule

bind rotation_error_angle rea_checker u_rea_checker (.*);
